>>> src/kruskal_union_find_engine_top_defines.svh
// Assertion macros shared by the union-find engine RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef KRUSKAL_UNION_FIND_ENGINE_TOP_DEFINES_SVH
`define KRUSKAL_UNION_FIND_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KUFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("union-find engine assertion failed");
`define KUFE_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("union-find engine assertion failed");
`else
`define KUFE_ASSERT(label, clk, rst_n, prop)
`define KUFE_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> src/kufe_pkg.sv
// Package of the union-find engine: controller states and fixed constants.
// No dependencies.
package kufe_pkg;
    localparam int RANK_W   = 4;
    localparam int RANK_MAX = 15;
    localparam int ROOT_W   = 10;
    localparam int COORD_W  = 5;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_UNION,
        S_BUMP
    } t_state;
endpackage

>>> src/kufe_mem.sv
// Simple dual-port synchronous memory holding rank and parent per cell.
// One write port, one read port with registered read data; no dependencies.
module kufe_mem #(
    parameter int AW = 10,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/kruskal_union_find_engine_top.sv
// Each item walks from the first cell to its root, then rewrites that path to point at the root,
// does the same for the second cell and then joins the two roots; equal ranks add an S_BUMP step.
// The time an item takes is set by the single read port of the cell memory, one entry per cycle.
// Out-of-range items give their result in the cycle after start. One item at a time.
// After reset a clearing pass over all MAX_ROWS * MAX_COLS cells initialises the memory with busy
// high; configuration writes are taken throughout. The receiver cannot stall results.
`include "kruskal_union_find_engine_top_defines.svh"
module kruskal_union_find_engine_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [kufe_pkg::COORD_W-1:0]   i_first_col,
    input  logic [kufe_pkg::COORD_W-1:0]   i_first_row,
    input  logic [kufe_pkg::COORD_W-1:0]   i_second_col,
    input  logic [kufe_pkg::COORD_W-1:0]   i_second_row,
    output logic                           o_done,
    output logic                           o_wall_removed,
    output logic [kufe_pkg::ROOT_W-1:0]    o_merged_root,
    output logic                           o_out_of_range,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kufe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kufe_pkg::CFG_W-1:0]     i_cfg_data
);
    import kufe_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IW    = $clog2(CELLS);
    localparam int DW    = IW + RANK_W;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);

    t_state r_state, n_state;
    logic [CFG_W-1:0]  r_cols, r_rows;
    logic [IW-1:0]     r_clr, n_clr;
    logic [IW-1:0]     r_cur, n_cur, r_start, n_start, r_idxb, n_idxb;
    logic [IW-1:0]     r_root, n_root, r_ra, n_ra, r_out_root, n_out_root;
    logic [RANK_W-1:0] r_rank_root, n_rank_root, r_rank_a, n_rank_a;
    logic              r_phase_b, n_phase_b;
    logic              r_done, n_done, r_removed, n_removed, r_oor, n_oor;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    logic [DW-1:0]     mem_wdata, mem_rdata;
    logic [IW-1:0]     rd_par;
    logic [RANK_W-1:0] rd_rank, rank_bump;

    logic [CW-1:0]     eff_cols;
    logic [RW-1:0]     eff_rows;
    logic              accept, oor, found, cells_same, rank_gt, rank_lt;
    logic [IW-1:0]     idx_a, idx_b;

    kufe_mem #(.AW(IW), .DW(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_par  = mem_rdata[IW-1:0];
    assign rd_rank = mem_rdata[DW-1:IW];
    assign rank_bump = (int'(r_rank_a) < RANK_MAX) ? r_rank_a + 1'b1 : r_rank_a;

    always_comb begin
        if (r_cols == '0) begin
            eff_cols = CW'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            eff_cols = CW'(MAX_COLS);
        end else begin
            eff_cols = CW'(r_cols);
        end
        if (r_rows == '0) begin
            eff_rows = RW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            eff_rows = RW'(MAX_ROWS);
        end else begin
            eff_rows = RW'(r_rows);
        end
    end

    assign oor = (int'(i_first_col) >= int'(eff_cols)) || (int'(i_second_col) >= int'(eff_cols))
              || (int'(i_first_row) >= int'(eff_rows)) || (int'(i_second_row) >= int'(eff_rows));
    assign idx_a = IW'(int'(i_first_row) * int'(eff_cols) + int'(i_first_col));
    assign idx_b = IW'(int'(i_second_row) * int'(eff_cols) + int'(i_second_col));

    assign o_busy      = (r_state != S_IDLE);
    assign accept      = i_start && !o_busy;
    assign found       = (rd_par == r_cur);
    assign cells_same  = (r_ra == r_root);
    assign rank_gt     = (r_rank_a > r_rank_root);
    assign rank_lt     = (r_rank_a < r_rank_root);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == IW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && !oor) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (found) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (r_cur == r_root) begin
                    n_state = r_phase_b ? S_UNION : S_WALK;
                end
            end
            S_UNION: begin
                n_state = (!cells_same && !rank_gt && !rank_lt) ? S_BUMP : S_IDLE;
            end
            S_BUMP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_start     = r_start;
        n_idxb      = r_idxb;
        n_root      = r_root;
        n_ra        = r_ra;
        n_rank_root = r_rank_root;
        n_rank_a    = r_rank_a;
        n_phase_b   = r_phase_b;
        n_done      = 1'b0;
        n_removed   = r_removed;
        n_out_root  = r_out_root;
        n_oor       = r_oor;
        mem_we      = 1'b0;
        mem_waddr   = r_cur;
        mem_wdata   = {rd_rank, r_root};
        mem_raddr   = r_cur;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = {{RANK_W{1'b0}}, r_clr};
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    if (oor) begin
                        n_done     = 1'b1;
                        n_oor      = 1'b1;
                        n_removed  = 1'b0;
                        n_out_root = '0;
                    end else begin
                        n_cur     = idx_a;
                        n_start   = idx_a;
                        n_idxb    = idx_b;
                        n_phase_b = 1'b0;
                        mem_raddr = idx_a;
                    end
                end
            end
            S_WALK: begin
                if (found) begin
                    n_root      = r_cur;
                    n_rank_root = rd_rank;
                    n_cur       = r_start;
                    mem_raddr   = r_start;
                end else begin
                    n_cur     = rd_par;
                    mem_raddr = rd_par;
                end
            end
            S_COMP: begin
                if (r_cur == r_root) begin
                    if (!r_phase_b) begin
                        n_ra      = r_root;
                        n_rank_a  = r_rank_root;
                        n_phase_b = 1'b1;
                        n_cur     = r_idxb;
                        n_start   = r_idxb;
                        mem_raddr = r_idxb;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {rd_rank, r_root};
                    n_cur     = rd_par;
                    mem_raddr = rd_par;
                end
            end
            S_UNION: begin
                n_oor = 1'b0;
                if (cells_same) begin
                    n_done     = 1'b1;
                    n_removed  = 1'b0;
                    n_out_root = r_ra;
                end else if (rank_lt) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_ra;
                    mem_wdata  = {r_rank_a, r_root};
                    n_done     = 1'b1;
                    n_removed  = 1'b1;
                    n_out_root = r_root;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_root;
                    mem_wdata  = {r_rank_root, r_ra};
                    n_done     = rank_gt;
                    n_removed  = 1'b1;
                    n_out_root = r_ra;
                end
            end
            S_BUMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_ra;
                mem_wdata = {rank_bump, r_ra};
                n_done    = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_cols  <= CFG_W'(32);
            r_rows  <= CFG_W'(32);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_GRID_COLUMNS: r_cols <= i_cfg_data;
                    REG_GRID_ROWS:    r_rows <= i_cfg_data;
                    default:          r_cols <= r_cols;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur       <= n_cur;
        r_start     <= n_start;
        r_idxb      <= n_idxb;
        r_root      <= n_root;
        r_ra        <= n_ra;
        r_rank_root <= n_rank_root;
        r_rank_a    <= n_rank_a;
        r_phase_b   <= n_phase_b;
        r_removed   <= n_removed;
        r_out_root  <= n_out_root;
        r_oor       <= n_oor;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_done         = r_done;
    assign o_wall_removed = r_removed;
    assign o_merged_root  = ROOT_W'(r_out_root);
    assign o_out_of_range = r_oor;

    `KUFE_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !o_done)
    `KUFE_ASSERT(a_no_write_idle, i_clk, i_rst_n, (r_state == S_IDLE) |-> !mem_we)
    `KUFE_ASSERT(a_oor_clean, i_clk, i_rst_n,
        (o_done && o_out_of_range) |-> (!o_wall_removed && (o_merged_root == '0)))
    `KUFE_ASSERT(a_bump_after_tie, i_clk, i_rst_n,
        (r_state == S_BUMP) |-> ($past(r_state) == S_UNION))
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the union-find engine top level.
// Depends on kufe_pkg and kruskal_union_find_engine_top; walls are predicted by a scoreboard class.
`timescale 1ns / 1ps
module testbench;
    import kufe_pkg::*;

    localparam int N_CELLS = 1024;

    class wall_scoreboard;
        logic [ROOT_W-1:0] parent_q [N_CELLS];
        logic [RANK_W-1:0] rank_q [N_CELLS];
        logic [CFG_W-1:0]  cols_reg;
        logic [CFG_W-1:0]  rows_reg;
        logic [ROOT_W+1:0] pending [$];
        int errors;

        function new();
            for (int i = 0; i < N_CELLS; i++) begin
                parent_q[i] = ROOT_W'(i);
                rank_q[i] = 0;
            end
            cols_reg = CFG_W'(32);
            rows_reg = CFG_W'(32);
            errors = 0;
        endfunction

        function void queue_expect(logic [ROOT_W+1:0] exp_beat);
            pending = {pending, exp_beat};
        endfunction

        function int find_root(int start_idx);
            int root;
            int cur;
            int nxt;
            root = start_idx;
            while (int'(parent_q[root]) != root) root = int'(parent_q[root]);
            cur = start_idx;
            while (cur != root) begin
                nxt = int'(parent_q[cur]);
                parent_q[cur] = ROOT_W'(root);
                cur = nxt;
            end
            return root;
        endfunction

        function void note_wall(int c1, int r1, int c2, int r2);
            int cols;
            int rows;
            int ra;
            int rb;
            int root;
            bit removed;
            cols = (cols_reg < 1) ? 1 : (cols_reg > 32) ? 32 : int'(cols_reg);
            rows = (rows_reg < 1) ? 1 : (rows_reg > 32) ? 32 : int'(rows_reg);
            if (c1 >= cols || c2 >= cols || r1 >= rows || r2 >= rows) begin
                queue_expect({1'b0, 10'd0, 1'b1});
                return;
            end
            ra = find_root(r1 * cols + c1);
            rb = find_root(r2 * cols + c2);
            root = ra;
            removed = 0;
            if (ra != rb) begin
                removed = 1;
                if (rank_q[ra] > rank_q[rb]) begin
                    parent_q[rb] = ROOT_W'(ra);
                end else if (rank_q[ra] < rank_q[rb]) begin
                    parent_q[ra] = ROOT_W'(rb);
                    root = rb;
                end else begin
                    parent_q[rb] = ROOT_W'(ra);
                    if (rank_q[ra] < RANK_MAX) rank_q[ra]++;
                end
            end
            queue_expect({removed, root[ROOT_W-1:0], 1'b0});
        endfunction

        function void check_result(bit removed, logic [ROOT_W-1:0] root, bit oor);
            logic [ROOT_W+1:0] exp_beat;
            if (pending.size() == 0) begin
                $error("result beat with no expectation");
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            if (removed !== exp_beat[ROOT_W+1]) begin
                $error("wall_removed expected %0d actual %0d", exp_beat[ROOT_W+1], removed);
                errors++;
            end
            if (root !== exp_beat[ROOT_W:1]) begin
                $error("merged_root expected %0d actual %0d", exp_beat[ROOT_W:1], root);
                errors++;
            end
            if (oor !== exp_beat[0]) begin
                $error("out_of_range expected %0d actual %0d", exp_beat[0], oor);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic [COORD_W-1:0] i_first_col = 0, i_first_row = 0, i_second_col = 0, i_second_row = 0;
    logic o_done, o_wall_removed, o_out_of_range;
    logic [ROOT_W-1:0] o_merged_root;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CFG_W-1:0] i_cfg_data = 0;

    wall_scoreboard sb = new();
    bit quiet_stretch = 0;

    kruskal_union_find_engine_top u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_wall_removed, o_merged_root, o_out_of_range);
    end

    task automatic send_wall(int c1, int r1, int c2, int r2);
        logic [COORD_W-1:0] c1_b;
        logic [COORD_W-1:0] r1_b;
        logic [COORD_W-1:0] c2_b;
        logic [COORD_W-1:0] r2_b;
        c1_b = COORD_W'(c1);
        r1_b = COORD_W'(r1);
        c2_b = COORD_W'(c2);
        r2_b = COORD_W'(r2);
        if (!quiet_stretch) begin
            while ($urandom_range(99) < 19) @(negedge i_clk);
        end
        i_first_col = c1_b;
        i_first_row = r1_b;
        i_second_col = c2_b;
        i_second_row = r2_b;
        i_start = 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_wall(int'(c1_b), int'(r1_b), int'(c2_b), int'(r2_b));
        @(negedge i_clk);
        i_start = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_GRID_COLUMNS) sb.cols_reg = val;
        else sb.rows_reg = val;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_walls(int n, int cols, int rows);
        int c1, r1, c2, r2;
        for (int i = 0; i < n; i++) begin
            quiet_stretch = (i >= n / 3 && i < n / 2);
            if ($urandom_range(9) == 0) begin
                send_wall($urandom, $urandom, $urandom, $urandom);
            end else begin
                c1 = $urandom_range(cols - 1);
                r1 = $urandom_range(rows - 1);
                c2 = c1;
                r2 = r1;
                case ($urandom_range(4))
                    0: if (c1 + 1 < cols) c2 = c1 + 1;
                    1: if (r1 + 1 < rows) r2 = r1 + 1;
                    2: ;
                    default: begin
                        c2 = $urandom_range(cols - 1);
                        r2 = $urandom_range(rows - 1);
                    end
                endcase
                send_wall(c1, r1, c2, r2);
            end
        end
        quiet_stretch = 0;
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        send_wall(0, 0, 1, 0);
        send_wall(31, 31, 30, 31);
        send_wall(0, 0, 0, 0);
        send_wall(1, 0, 0, 0);
        send_wall(0, 0, 31, 31);
        send_wall(31, 31, 0, 0);
        send_wall(5, 7, 20, 3);
        drain();
        write_reg(REG_GRID_COLUMNS, 4);
        write_reg(REG_GRID_ROWS, 3);
        send_wall(4, 0, 0, 0);
        send_wall(0, 0, 0, 3);
        send_wall(3, 2, 2, 2);
        send_wall(31, 31, 31, 31);
        drain();
        write_reg(REG_GRID_COLUMNS, 0);
        write_reg(REG_GRID_ROWS, 0);
        send_wall(0, 0, 0, 0);
        send_wall(1, 0, 0, 0);
        drain();
        write_reg(REG_GRID_COLUMNS, 63);
        write_reg(REG_GRID_ROWS, 40);
        send_wall(31, 31, 0, 0);
        send_wall(16, 8, 1, 2);
        drain();
        random_walls(500, 32, 32);
        drain();
        write_reg(REG_GRID_COLUMNS, 1);
        write_reg(REG_GRID_ROWS, 32);
        random_walls(150, 1, 32);
        drain();
        write_reg(REG_GRID_COLUMNS, 7);
        write_reg(REG_GRID_ROWS, 5);
        random_walls(300, 7, 5);
        drain();
        write_reg(REG_GRID_COLUMNS, 32);
        write_reg(REG_GRID_ROWS, 1);
        random_walls(150, 32, 1);
        drain();
        write_reg(REG_GRID_COLUMNS, 32);
        write_reg(REG_GRID_ROWS, 32);
        random_walls(250, 32, 32);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
